// ----- src/wpsc_pkg.sv -----
// Shared constants and controller/datapath interface types for the wheel prime sieve counter.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package wpsc_pkg;

   localparam int MaxBoundDefault = 65535;
   localparam int BoundWidth      = 16;
   localparam int CountWidth      = 13;

   // Commands from the controller to the datapath, at most one active per cycle.
   typedef struct packed {
      logic load;
      logic seed;
      logic base_read;
      logic base_start;
      logic mark;
      logic base_next;
      logic scan_init;
      logic scan;
   } wpsc_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic seed_last;
      logic sieve_over;
      logic base_set;
      logic mark_over;
      logic scan_over;
   } wpsc_status_type;

endpackage

// ----- src/wpsc_datapath.sv -----
// Datapath of the wheel prime sieve counter: candidate map memory, index counters and count.
// Depends on wpsc_pkg for the command and status types and the field widths.
`timescale 1ns / 1ps

module wpsc_datapath #(
   parameter int MAX_BOUND = wpsc_pkg::MaxBoundDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [wpsc_pkg::BoundWidth-1:0]   req_upper_bound,
   input  wpsc_pkg::wpsc_cmd_type            cmd,
   output wpsc_pkg::wpsc_status_type         status,
   output logic [wpsc_pkg::CountWidth-1:0]   prime_count
);

   localparam int AW = $clog2(MAX_BOUND + 1);
   localparam int XW = AW + 1;
   localparam int CW = wpsc_pkg::CountWidth;

   logic           map_mem [MAX_BOUND + 1];

   logic [AW-1:0]  n_ff;
   logic [XW-1:0]  v_ff;
   logic [2:0]     vmod_ff;
   logic [AW-1:0]  p_ff;
   logic [2:0]     pmod_ff;
   logic [XW-1:0]  sq_ff;
   logic [XW-1:0]  m_ff;
   logic           stride_big_ff;
   logic           rd_ff;
   logic           vld_ff;
   logic [CW-1:0]  count_ff;

   logic [AW-1:0]  n_sat;
   logic [XW-1:0]  n_ext;
   logic [XW-1:0]  p_twice;
   logic [XW-1:0]  p_four;
   logic           seed_bit;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic           wr_data;
   logic           rd_en;
   logic [AW-1:0]  rd_addr;
   logic [CW-1:0]  small_count;

   always_comb begin
      if (32'(req_upper_bound) > 32'(MAX_BOUND)) begin
         n_sat = AW'(MAX_BOUND);
      end else begin
         n_sat = AW'(req_upper_bound);
      end
   end

   assign n_ext   = XW'(n_ff);
   assign p_twice = XW'(p_ff) << 1;
   assign p_four  = XW'(p_ff) << 2;

   // Only numbers of the form 6k+1 and 6k+5 from five upward start as candidates.
   assign seed_bit = (v_ff >= XW'(5)) && ((vmod_ff == 3'd1) || (vmod_ff == 3'd5));

   assign wr_en   = cmd.seed | cmd.mark;
   assign wr_addr = cmd.seed ? v_ff[AW-1:0] : m_ff[AW-1:0];
   assign wr_data = cmd.seed & seed_bit;
   assign rd_en   = cmd.base_read | cmd.scan;
   assign rd_addr = cmd.base_read ? p_ff : v_ff[AW-1:0];

   assign small_count = (n_ff >= AW'(3)) ? CW'(2) : ((n_ff >= AW'(2)) ? CW'(1) : CW'(0));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= map_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff    <= n_sat;
         v_ff    <= '0;
         vmod_ff <= 3'd0;
         p_ff    <= AW'(5);
         pmod_ff <= 3'd5;
         sq_ff   <= XW'(25);
      end
      if (cmd.seed) begin
         v_ff    <= v_ff + XW'(1);
         vmod_ff <= (vmod_ff == 3'd5) ? 3'd0 : vmod_ff + 3'd1;
      end
      // A base of the form 6k+5 takes a cofactor step of two first, 6k+1 a step of four.
      if (cmd.base_start) begin
         m_ff          <= sq_ff;
         stride_big_ff <= (pmod_ff != 3'd5);
      end
      if (cmd.mark) begin
         m_ff          <= m_ff + (stride_big_ff ? p_four : p_twice);
         stride_big_ff <= ~stride_big_ff;
      end
      // The square follows the base: (p+2)^2 = p^2 + 4p + 4.
      if (cmd.base_next) begin
         p_ff    <= p_ff + AW'(2);
         sq_ff   <= sq_ff + p_four + XW'(4);
         pmod_ff <= (pmod_ff == 3'd5) ? 3'd1 : pmod_ff + 3'd2;
      end
      if (cmd.scan_init) begin
         v_ff     <= XW'(5);
         count_ff <= small_count;
      end
      if (cmd.scan) begin
         v_ff <= v_ff + XW'(1);
      end
      if (vld_ff) begin
         count_ff <= count_ff + CW'(rd_ff);
      end
   end

   assign status.seed_last  = (v_ff == n_ext);
   assign status.sieve_over = (sq_ff > n_ext);
   assign status.base_set   = rd_ff;
   assign status.mark_over  = (m_ff > n_ext);
   assign status.scan_over  = (v_ff > n_ext);

   assign prime_count = count_ff;

endmodule

// ----- src/wpsc_ctrl.sv -----
// Controller of the wheel prime sieve counter: sequences seeding, sieving and counting.
// Depends on wpsc_pkg for the command and status types.
`timescale 1ns / 1ps

module wpsc_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  wpsc_pkg::wpsc_status_type  status,
   output wpsc_pkg::wpsc_cmd_type     cmd,
   output logic                       busy,
   output logic                       rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_CHECK,
      ST_TEST,
      ST_MARK,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !busy_ff) begin
               cmd.load = 1'b1;
               busy_in  = 1'b1;
               state_in = ST_SEED;
            end
         end
         ST_SEED: begin
            cmd.seed = 1'b1;
            if (status.seed_last) begin
               state_in = ST_CHECK;
            end
         end
         // The read of the base issued here returns its map bit in the test state.
         ST_CHECK: begin
            if (status.sieve_over) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end else begin
               cmd.base_read = 1'b1;
               state_in      = ST_TEST;
            end
         end
         ST_TEST: begin
            if (status.base_set) begin
               cmd.base_start = 1'b1;
               state_in       = ST_MARK;
            end else begin
               cmd.base_next = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_MARK: begin
            if (status.mark_over) begin
               cmd.base_next = 1'b1;
               state_in      = ST_CHECK;
            end else begin
               cmd.mark = 1'b1;
            end
         end
         // The last map bit is added on the edge that leaves this state.
         ST_SCAN: begin
            if (status.scan_over) begin
               busy_in      = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy_ff) |=> busy_ff)
      else $error("accepted request did not raise busy");

   a_result_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!busy_ff && state_ff == ST_IDLE))
      else $error("result strobe while a request is still in work");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(start))
      else $error("busy rose without a start");

endmodule

// ----- src/wheel_prime_sieve_counter.sv -----
// For a bound N (saturated to MAX_BOUND) the block seeds the map for every value up to N,
// then for each odd base p from five with p*p <= N checks and tests it and, when p is still
// a candidate, clears its multiples; it then leaves the sieve, scans from five up to N (not
// at all when N < 5) and adds the last bit; the strobe follows in the next cycle.
// One request is in work at a time; the next one can be taken in the strobe cycle. Reset is
// synchronous and returns the block to idle; every request reseeds the map before reading it.
`timescale 1ns / 1ps

module wheel_prime_sieve_counter #(
   parameter int MAX_BOUND = wpsc_pkg::MaxBoundDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [wpsc_pkg::BoundWidth-1:0]  req_upper_bound,
   output logic                             rsp_valid,
   output logic [wpsc_pkg::CountWidth-1:0]  rsp_prime_count
);

   wpsc_pkg::wpsc_cmd_type    cmd;
   wpsc_pkg::wpsc_status_type status;

   wpsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   wpsc_datapath #(
      .MAX_BOUND (MAX_BOUND)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_upper_bound (req_upper_bound),
      .cmd             (cmd),
      .status          (status),
      .prime_count     (rsp_prime_count)
   );

endmodule
